FILE: design/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/usbsx_pkg.sv
// Package with codes, constants and types of the USB-MIDI SysEx reassembler.
package usbsx_pkg;

  // Code index numbers of the packet header low nibble
  localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
  localparam logic [3:0] CIN_SYSEX_END1 = 4'h5;
  localparam logic [3:0] CIN_SYSEX_END2 = 4'h6;
  localparam logic [3:0] CIN_SYSEX_END3 = 4'h7;
  localparam logic [3:0] CIN_SINGLE     = 4'hF;

  // MIDI framing bytes
  localparam logic [7:0] BYTE_SOX = 8'hF0;
  localparam logic [7:0] BYTE_EOX = 8'hF7;

  // Length limit after reset
  localparam logic [15:0] LIMIT_RESET = 16'd256;

  // Smallest position at which an end or a data byte is accepted
  localparam logic [15:0] POS_MIN_END = 16'd3;

  typedef enum logic [2:0] {
    EV_IGNORED  = 3'd0,
    EV_APPENDED = 3'd1,
    EV_COMPLETE = 3'd2,
    EV_INVALID  = 3'd3,
    EV_OVERFLOW = 3'd4,
    EV_STRAY    = 3'd5
  } event_e;

  // One input packet
  typedef struct packed {
    logic [7:0] data_byte_c;
    logic [7:0] data_byte_b;
    logic [7:0] data_byte_a;
    logic [7:0] header_byte;
  } packet_t;

  // One result item
  typedef struct packed {
    event_e      event_code;
    logic [1:0]  append_count;
    logic [7:0]  append_first;
    logic [7:0]  append_second;
    logic [7:0]  append_third;
    logic [15:0] message_length;
  } result_t;

  // Running message state
  typedef struct packed {
    logic [15:0] fill_position;
    logic        starts_with_sysex;
  } msg_state_t;

endpackage

FILE: design/usbsx_decode.sv
// Per-packet decode: result item and next message state from one packet.
module usbsx_decode import usbsx_pkg::*; (
  input  packet_t     pkt_i,
  input  msg_state_t  state_i,
  input  logic [15:0] length_limit_i,
  output result_t     result_o,
  output msg_state_t  state_o
);

  logic [3:0]  cin;
  logic [1:0]  num_bytes;
  logic [16:0] new_len;
  logic        overflow;
  logic        pos_ok;
  logic [7:0]  last_byte;

  assign cin = pkt_i.header_byte[3:0];

  // Pick the append size: three for start/continue, 1..3 for end, one otherwise
  always_comb begin
    unique case (cin)
      CIN_SYSEX_CONT: num_bytes = 2'd3;
      CIN_SYSEX_END1: num_bytes = 2'd1;
      CIN_SYSEX_END2: num_bytes = 2'd2;
      CIN_SYSEX_END3: num_bytes = 2'd3;
      default:        num_bytes = 2'd1;
    endcase
  end

  // One adder and one compare against the limit serve every path
  assign new_len  = {1'b0, state_i.fill_position} + {15'd0, num_bytes};
  assign overflow = new_len > {1'b0, length_limit_i};
  assign pos_ok   = state_i.fill_position >= POS_MIN_END;

  always_comb begin
    unique case (num_bytes)
      2'd1:    last_byte = pkt_i.data_byte_a;
      2'd2:    last_byte = pkt_i.data_byte_b;
      default: last_byte = pkt_i.data_byte_c;
    endcase
  end

  // Classify the packet and form the next state
  always_comb begin
    msg_state_t clr;
    clr.fill_position     = '0;
    clr.starts_with_sysex = 1'b0;

    result_o = '{event_code: EV_IGNORED, append_count: 2'd0, append_first: 8'd0,
                 append_second: 8'd0, append_third: 8'd0, message_length: 16'd0};
    state_o  = state_i;

    unique case (cin)
      CIN_SYSEX_CONT: begin
        if (overflow) begin
          result_o.event_code = EV_OVERFLOW;
          state_o = clr;
        end else begin
          if (state_i.fill_position == 16'd0) begin
            state_o.starts_with_sysex = (pkt_i.data_byte_a == BYTE_SOX);
          end
          state_o.fill_position = new_len[15:0];
          result_o.event_code   = EV_APPENDED;
          result_o.append_count = 2'd3;
          result_o.append_first = pkt_i.data_byte_a;
          result_o.append_second = pkt_i.data_byte_b;
          result_o.append_third = pkt_i.data_byte_c;
        end
      end
      CIN_SYSEX_END1, CIN_SYSEX_END2, CIN_SYSEX_END3: begin
        state_o = clr;
        priority if (!pos_ok || !state_i.starts_with_sysex || last_byte != BYTE_EOX) begin
          result_o.event_code = EV_INVALID;
        end else if (overflow) begin
          result_o.event_code = EV_OVERFLOW;
        end else begin
          result_o.event_code     = EV_COMPLETE;
          result_o.append_count   = num_bytes;
          result_o.append_first   = pkt_i.data_byte_a;
          result_o.append_second  = (num_bytes >= 2'd2) ? pkt_i.data_byte_b : 8'd0;
          result_o.append_third   = (num_bytes == 2'd3) ? pkt_i.data_byte_c : 8'd0;
          result_o.message_length = new_len[15:0];
        end
      end
      CIN_SINGLE: begin
        priority if (pkt_i.data_byte_a == BYTE_EOX && pos_ok) begin
          state_o = clr;
          if (overflow) begin
            result_o.event_code = EV_OVERFLOW;
          end else begin
            result_o.event_code     = EV_COMPLETE;
            result_o.append_count   = 2'd1;
            result_o.append_first   = pkt_i.data_byte_a;
            result_o.message_length = new_len[15:0];
          end
        end else if (pkt_i.data_byte_a[7]) begin
          // Any other byte with bit 7 set, such as a real-time byte: keep state
          result_o.event_code = EV_IGNORED;
        end else if (pos_ok) begin
          if (overflow) begin
            result_o.event_code = EV_OVERFLOW;
            state_o = clr;
          end else begin
            state_o.fill_position = new_len[15:0];
            result_o.event_code   = EV_APPENDED;
            result_o.append_count = 2'd1;
            result_o.append_first = pkt_i.data_byte_a;
          end
        end else begin
          result_o.event_code = EV_STRAY;
          state_o = clr;
        end
      end
      default: begin
        result_o.event_code = EV_IGNORED;
      end
    endcase
  end

endmodule

FILE: design/usb_midi_sysex_reassembler.sv
// Top level of the USB-MIDI SysEx reassembler: input, state and result registers.
// Takes one 4-byte USB-MIDI event packet per transaction and returns one result
// per packet: an event code in tuser and the bytes to append plus the message
// length in tdata. One packet is accepted every cycle while the result side is
// ready. A packet is captured in the input register, and its result is loaded
// from there into the result register when that register is free or being read.
// A stalled result holds the input register, and tready drops once that register
// is full. The rate is set by the running fill position, which passes through a
// single 17-bit add and limit compare per packet. The user must write the length
// limit through cfg_we_i and cfg_wdata_i only while no packet is in flight; the
// block does not enforce this. The limit resets to 256.
module usb_midi_sysex_reassembler import usbsx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: length limit
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // Packet input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] header_byte, [15:8] data_byte_a, [23:16] data_byte_b, [31:24] data_byte_c
  input  logic [31:0] s_axis_tdata,
  // Result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] append_count, [9:2] append_first, [17:10] append_second,
  // [25:18] append_third, [41:26] message_length, [47:42] zero
  output logic [47:0] m_axis_tdata,
  // [2:0] event_code
  output logic [2:0]  m_axis_tuser
);

  logic        in_valid_q;
  packet_t     in_pkt_q;
  logic        out_valid_q;
  result_t     out_q;
  msg_state_t  state_q;
  msg_state_t  state_d;
  result_t     result_d;
  logic [15:0] limit_q;
  logic        advance;
  logic        in_take;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  usbsx_decode u_decode (
    .pkt_i          (in_pkt_q),
    .state_i        (state_q),
    .length_limit_i (limit_q),
    .result_o       (result_d),
    .state_o        (state_d)
  );

  // Hold the length limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Capture the packet of each input transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_pkt_q <= packet_t'(s_axis_tdata);
    end
  end

  // Advance the message state as each packet moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Hold the result until the output transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.event_code;
  assign m_axis_tdata  = {6'd0, out_q.message_length, out_q.append_third,
                          out_q.append_second, out_q.append_first, out_q.append_count};

endmodule

FILE: design/usbsx_checker.sv
// Port-level checker for the USB-MIDI SysEx reassembler, bound to the top level.
`include "assert_macros.svh"

module usbsx_checker import usbsx_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  logic carries_bytes;
  logic is_complete;
  logic out_stalled;
  logic event_ok;
  logic bare_event;
  logic payload_zero;
  logic out_complete;
  logic complete_ok;

  assign carries_bytes = (m_axis_tuser == EV_APPENDED) || (m_axis_tuser == EV_COMPLETE);
  assign is_complete   = m_axis_tuser == EV_COMPLETE;
  assign out_stalled   = m_axis_tvalid && !m_axis_tready;
  assign event_ok      = m_axis_tuser <= EV_STRAY;
  assign bare_event    = m_axis_tvalid && !carries_bytes;
  assign payload_zero  = m_axis_tdata == 48'd0;
  assign out_complete  = m_axis_tvalid && is_complete;
  assign complete_ok   = (m_axis_tdata[41:26] >= 16'd4) && (m_axis_tdata[1:0] != 2'd0);

  // A stalled result stays offered
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_stalled |=> m_axis_tvalid, "stalled result dropped")

  // Event codes never go past stray rejected
  `ASSERT_ALWAYS(a_event_range, clk_i, m_axis_tvalid |-> event_ok, "event code out of range")

  // Events without bytes carry an all-zero payload
  `ASSERT_CLK(a_empty_payload, clk_i, rst_ni, bare_event |-> payload_zero, "stray payload")

  // A complete message is at least four bytes and appends at least one byte
  `ASSERT_CLK(a_complete_len, clk_i, rst_ni, out_complete |-> complete_ok, "short message")

endmodule

bind usb_midi_sysex_reassembler usbsx_checker u_usbsx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
